@@ rtl/core/shared_buffer_multi_queue_assert.svh @@
// Assertion macros for the shared-pool multi-queue.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication
`define SBMQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbmq: same-cycle check failed");

// Next-cycle implication
`define SBMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbmq: next-cycle check failed");

`endif

@@ rtl/core/sbmq_pkg.sv @@
`timescale 1ns / 1ps
package sbmq_pkg;

  // Request command
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Fixed widths of the request and result fields
  localparam int unsigned QID_W  = 3;
  localparam int unsigned WORD_W = 32;

endpackage

@@ rtl/core/sbmq_ram.sv @@
`timescale 1ns / 1ps
module sbmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/shared_buffer_multi_queue.sv @@
`timescale 1ns / 1ps
// Channel   | Handshake              | Payload
// ----------+------------------------+--------------------------------
// request   | start_i / busy_o       | command_i, queue_id_i, data_in_i
// result    | done_o (1-cycle pulse) | status_o, data_out_o
//
// Each request has an accept cycle, which issues the link and data memory reads,
// and an execute cycle, which uses the registered read data and writes back.
// The result is shown in the cycle after that, while the next request is taken.
// busy_o is high during the execute cycle only; the receiver cannot stall.
// Reset needs no clearing pass: untouched link entries are covered by a fill
// count, so a request can be taken as soon as reset is released.
module shared_buffer_multi_queue #(
  parameter int unsigned CELLS      = 64,
  parameter int unsigned QUEUES     = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 command_i,
  input  logic [sbmq_pkg::QID_W-1:0]           queue_id_i,
  input  logic signed [sbmq_pkg::WORD_W-1:0]   data_in_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [sbmq_pkg::WORD_W-1:0]   data_out_o
);

  import sbmq_pkg::*;

  // Pointer width covers the null code CELLS
  localparam int unsigned PW  = $clog2(CELLS + 1);
  localparam int unsigned CIW = $clog2(CELLS);
  localparam int unsigned SW  = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam int unsigned QN  = (QUEUES < (1 << QID_W)) ? QUEUES : (1 << QID_W);
  localparam int unsigned QIW = (QN > 1) ? $clog2(QN) : 1;
  localparam int unsigned QD  = 1 << QIW;
  localparam logic [PW-1:0] NULL_PTR = PW'(CELLS);

  state_e          state_q, state_d;
  logic [PW-1:0]   free_head_q;
  logic [PW-1:0]   fill_q;
  logic [PW-1:0]   head_q [QD];
  logic [PW-1:0]   tail_q [QD];

  cmd_e            cmd_q;
  logic [QIW-1:0]  qidx_q;
  logic            refuse_q;
  logic [PW-1:0]   cell_q;
  logic            untouched_q;

  logic            done_q;
  status_e         status_q;
  logic [WORD_W-1:0] data_out_q;

  logic            accept;
  cmd_e            cmd_in;
  logic            q_in_range;
  logic [QIW-1:0]  qidx;
  logic [PW-1:0]   cur_head;
  logic [PW-1:0]   cur_tail;
  logic            refuse;
  logic [PW-1:0]   slot;
  logic            exec_ok;
  logic [PW-1:0]   link_next;

  logic            link_we;
  logic [CIW-1:0]  link_waddr;
  logic [PW-1:0]   link_wdata;
  logic            link_re;
  logic [PW-1:0]   link_rdata;
  logic            data_we;
  logic            data_re;
  logic [SW-1:0]   data_rdata;

  // Decode the request
  assign accept     = start_i && !busy_o;
  assign cmd_in     = cmd_e'(command_i);
  assign q_in_range = ({{(32 - QID_W){1'b0}}, queue_id_i} < 32'(QUEUES));
  assign qidx       = queue_id_i[QIW-1:0];
  assign cur_head   = head_q[qidx];
  assign cur_tail   = tail_q[qidx];
  assign slot       = (cmd_in == CMD_PUSH) ? free_head_q : cur_head;
  assign refuse     = !q_in_range || (slot == NULL_PTR);

  // Execute cycle of a request that goes ahead
  assign exec_ok    = (state_q == S_EXEC) && !refuse_q;

  // Entries never allocated still hold their reset link
  assign link_next  = untouched_q ? (cell_q + PW'(1)) : link_rdata;

  // Link memory: chain behind the tail at accept, relink the cell afterward
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_tail[CIW-1:0];
    link_wdata = free_head_q;
    if (exec_ok) begin
      link_we    = 1'b1;
      link_waddr = cell_q[CIW-1:0];
      link_wdata = (cmd_q == CMD_PUSH) ? NULL_PTR : free_head_q;
    end else if (accept && !refuse && (cmd_in == CMD_PUSH) &&
                 (cur_head != NULL_PTR) && (cur_tail != NULL_PTR)) begin
      link_we = 1'b1;
    end
  end

  assign link_re = accept && !refuse;
  assign data_we = accept && !refuse && (cmd_in == CMD_PUSH);
  assign data_re = accept && !refuse && (cmd_in == CMD_POP);

  sbmq_ram #(
    .WIDTH (PW),
    .DEPTH (CELLS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (slot[CIW-1:0]),
    .rdata_o (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (SW),
    .DEPTH (CELLS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot[CIW-1:0]),
    .wdata_i (data_in_i[SW-1:0]),
    .re_i    (data_re),
    .raddr_i (slot[CIW-1:0]),
    .rdata_o (data_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    case (state_q)
      S_IDLE:  busy_o = 1'b0;
      S_EXEC:  busy_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= cmd_in;
      qidx_q      <= qidx;
      refuse_q    <= refuse;
      cell_q      <= slot;
      untouched_q <= (slot >= fill_q);
    end
  end

  // Advance free list, fill count and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < QD; i++) begin
        head_q[i] <= NULL_PTR;
        tail_q[i] <= NULL_PTR;
      end
    end else if (exec_ok) begin
      if (cmd_q == CMD_PUSH) begin
        free_head_q    <= link_next;
        tail_q[qidx_q] <= cell_q;
        if (head_q[qidx_q] == NULL_PTR) begin
          head_q[qidx_q] <= cell_q;
        end
        if (cell_q == fill_q) begin
          fill_q <= fill_q + PW'(1);
        end
      end else begin
        head_q[qidx_q] <= link_next;
        free_head_q    <= cell_q;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      if (refuse_q) begin
        if (cmd_q == CMD_PUSH) begin
          status_q <= STATUS_FULL;
        end else begin
          status_q <= STATUS_EMPTY;
        end
        data_out_q <= '0;
      end else begin
        status_q   <= STATUS_OK;
        data_out_q <= (cmd_q == CMD_POP) ? WORD_W'(signed'(data_rdata)) : '0;
      end
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = data_out_q;

`include "shared_buffer_multi_queue_assert.svh"

  `SBMQ_ASSERT_NEXT(a_result_follows_exec, busy_o, done_o && !busy_o)
  `SBMQ_ASSERT_NOW(a_free_head_in_range, 1'b1, free_head_q <= NULL_PTR)
  `SBMQ_ASSERT_NOW(a_fill_in_range, 1'b1, fill_q <= NULL_PTR)
  `SBMQ_ASSERT_NOW(a_exec_cell_valid, exec_ok, cell_q < NULL_PTR)

endmodule

@@ tb/sbmq_pool_checker.sv @@
`timescale 1ns / 1ps
module sbmq_pool_checker #(
  parameter int unsigned CELLS      = 64,
  parameter int unsigned QUEUES     = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_o,
  input  logic                                 command_i,
  input  logic [sbmq_pkg::QID_W-1:0]           queue_id_i,
  input  logic signed [sbmq_pkg::WORD_W-1:0]   data_in_i,
  input  logic                                 done_o,
  input  logic [1:0]                           status_o,
  input  logic signed [sbmq_pkg::WORD_W-1:0]   data_out_o,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import sbmq_pkg::*;

  localparam int unsigned PTR_W = $clog2(CELLS + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CELLS);

  typedef struct packed {
    status_e                   status;
    logic signed [WORD_W-1:0]  data;
  } outcome_t;

  // Shadow copy of the pool: cell words, links, queue ends and free list
  logic [WORD_W-1:0] cell_word [CELLS];
  logic [PTR_W-1:0]  next_cell [CELLS];
  logic [PTR_W-1:0]  q_head    [QUEUES];
  logic [PTR_W-1:0]  q_tail    [QUEUES];
  logic [PTR_W-1:0]  free_ptr;

  outcome_t outcome_q[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  // Chain the whole pool into one free list, all queues empty
  task automatic reset_pool();
    for (int i = 0; i < CELLS; i++) begin
      cell_word[i] = '0;
      next_cell[i] = PTR_W'(i + 1);
    end
    next_cell[CELLS-1] = NULL_PTR;
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = NULL_PTR;
      q_tail[i] = NULL_PTR;
    end
    free_ptr = '0;
  endtask

  // Sign-extend a stored word from DATA_WIDTH bits
  function automatic logic [WORD_W-1:0] widen_word(logic [WORD_W-1:0] v);
    for (int b = DATA_WIDTH; b < WORD_W; b++) begin
      v[b] = v[DATA_WIDTH-1];
    end
    return v;
  endfunction

  // Apply one request to the shadow pool and return the result it causes
  function automatic outcome_t apply_request(cmd_e cmd, logic [QID_W-1:0] qid,
                                             logic [WORD_W-1:0] din);
    outcome_t         res;
    logic [PTR_W-1:0] slot;
    res.status = STATUS_OK;
    res.data   = '0;
    if (cmd == CMD_PUSH) begin
      if (int'(qid) >= QUEUES || free_ptr == NULL_PTR) begin
        res.status = STATUS_FULL;
      end else begin
        slot     = free_ptr;
        free_ptr = next_cell[slot];
        // an empty queue restarts at the new cell, ignoring a stale tail
        if (q_head[qid] == NULL_PTR) begin
          q_head[qid] = slot;
        end else if (q_tail[qid] != NULL_PTR) begin
          next_cell[q_tail[qid]] = slot;
        end
        next_cell[slot] = NULL_PTR;
        q_tail[qid]     = slot;
        cell_word[slot] = din;
      end
    end else begin
      if (int'(qid) >= QUEUES || q_head[qid] == NULL_PTR) begin
        res.status = STATUS_EMPTY;
      end else begin
        slot            = q_head[qid];
        q_head[qid]     = next_cell[slot];
        next_cell[slot] = free_ptr;
        free_ptr        = slot;
        res.data        = widen_word(cell_word[slot]);
      end
    end
    return res;
  endfunction

  // Compare each result with the oldest prediction, then predict new requests
  always @(posedge clk_i or negedge rst_ni) begin : track
    outcome_t want;
    if (!rst_ni) begin
      reset_pool();
      outcome_q.delete();
      fail_count_o = 0;
    end else begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = outcome_q.pop_front();
          if (status_o !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      status_o, want.status));
          end
          if (data_out_o !== want.data) begin
            report_mismatch($sformatf("data_out %h, predicted %h",
                                      data_out_o, want.data));
          end
        end
      end
      if (start_i && !busy_o) begin
        outcome_q.push_back(apply_request(cmd_e'(command_i), queue_id_i, data_in_i));
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import sbmq_pkg::*;

  localparam int ITEMS     = 500;
  localparam int IDLE_MAX  = 2000;
  localparam int DRAIN     = 8;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic                      command_i;
  logic [QID_W-1:0]          queue_id_i;
  logic signed [WORD_W-1:0]  data_in_i;
  logic                      done_o;
  logic [1:0]                status_o;
  logic signed [WORD_W-1:0]  data_out_o;
  int                        fail_count;
  int                        pending;
  int                        sent;
  int                        idle_cycles;
  bit                        no_idle;

  shared_buffer_multi_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .queue_id_i (queue_id_i),
    .data_in_i  (data_in_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .data_out_o (data_out_o)
  );

  sbmq_pool_checker pool_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .queue_id_i   (queue_id_i),
    .data_in_i    (data_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Drive one request and hold it until the block takes it
  task automatic send_request(input cmd_e cmd, input logic [QID_W-1:0] qid,
                              input logic [WORD_W-1:0] din);
    @(negedge clk_i);
    start_i    <= 1'b1;
    command_i  <= cmd;
    queue_id_i <= qid;
    data_in_i  <= din;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  // Lower start for a random number of cycles: mostly none or short, a few long
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(input cmd_e cmd, input logic [QID_W-1:0] qid,
                       input logic [WORD_W-1:0] din);
    send_request(cmd, qid, din);
    idle_gap();
  endtask

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("shared_buffer_multi_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int        push_pct;
    int        span;
    logic [QID_W-1:0] base_q;
    logic [QID_W-1:0] qid;
    bit        focused;
    bit        first_phase;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    command_i   = 1'b0;
    queue_id_i  = '0;
    data_in_i   = '0;
    sent        = 0;
    no_idle     = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pops on empty queues, extreme words through the end queues
    issue(CMD_POP,  3'd0, $urandom);
    issue(CMD_POP,  3'd7, $urandom);
    issue(CMD_PUSH, 3'd0, 32'h7fff_ffff);
    issue(CMD_PUSH, 3'd0, 32'h8000_0000);
    issue(CMD_PUSH, 3'd7, 32'h0000_0000);
    issue(CMD_PUSH, 3'd7, 32'hffff_ffff);
    issue(CMD_POP,  3'd0, $urandom);
    issue(CMD_POP,  3'd0, $urandom);
    issue(CMD_POP,  3'd0, $urandom);
    issue(CMD_POP,  3'd7, $urandom);
    issue(CMD_POP,  3'd7, $urandom);
    // Empty a queue, then restart it past its stale tail
    issue(CMD_PUSH, 3'd3, 32'h1234_5678);
    issue(CMD_POP,  3'd3, $urandom);
    issue(CMD_PUSH, 3'd3, 32'hdead_beef);
    issue(CMD_PUSH, 3'd3, 32'h5a5a_a5a5);
    issue(CMD_POP,  3'd3, $urandom);
    issue(CMD_POP,  3'd3, $urandom);
    issue(CMD_POP,  3'd3, $urandom);

    // Random phases: fill-heavy, drain-heavy or mixed, some on two queues only
    first_phase = 1'b1;
    while (sent < ITEMS) begin
      if (first_phase) begin
        push_pct = 90;
        span     = 100;
      end else begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        span = $urandom_range(30, 90);
      end
      first_phase = 1'b0;
      focused = 1'($urandom_range(0, 1));
      base_q  = QID_W'($urandom_range(0, 7));
      no_idle = ($urandom_range(0, 2) == 0);
      repeat (span) begin
        if (sent >= ITEMS) break;
        qid = focused ? (base_q ^ QID_W'($urandom_range(0, 1))) : QID_W'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < push_pct) issue(CMD_PUSH, qid, pick_word());
        else issue(CMD_POP, qid, $urandom);
      end
    end

    // Drain outstanding results, then watch for stray ones
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("shared_buffer_multi_queue: match");
    end else begin
      $display("shared_buffer_multi_queue: mismatch");
    end
    $finish;
  end

endmodule
